// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ----- sv/thadc_pkg.sv -----
`timescale 1ns / 1ps

package thadc_pkg;

   localparam int TABLE_STORED          = 39;
   localparam int TABLE_POINTS_DEFAULT  = 39;
   localparam int FRACTION_BITS_DEFAULT = 8;

   localparam int HOT_DEGREES    = 150;
   localparam int STEP_DEGREES   = 5;
   localparam int TENTHS_PER_OHM = 10;

   localparam int READING_WIDTH = 16;
   localparam int SERIES_WIDTH  = 20;
   localparam int TEMP_WIDTH    = 17;
   localparam int STATUS_WIDTH  = 2;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 20;

   localparam int RES_WIDTH    = 22;
   localparam int SPAN_WIDTH   = 20;
   localparam int IDX_WIDTH    = 6;
   localparam int DEG_WIDTH    = 9;
   localparam int SCALED_WIDTH = 24;
   localparam int WORK_WIDTH   = 40;
   localparam int REM_WIDTH    = 21;
   localparam int CNT_WIDTH    = 6;
   localparam int STEP_BITS    = 3;

   localparam logic [READING_WIDTH-1:0] FULL_SCALE_RESET = 16'd1023;
   localparam logic [SERIES_WIDTH-1:0]  SERIES_RESET     = 20'd10000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FULL_SCALE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SERIES     = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_IN_RANGE = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_HOT      = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_COLD     = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SCAN,
      ST_PREP,
      ST_LOAD2,
      ST_DIV2,
      ST_SUB,
      ST_DONE
   } state_type;

   localparam logic [RES_WIDTH-1:0] RES_TENTHS [TABLE_STORED] = '{
      22'd1861,    22'd2090,    22'd2354,    22'd2658,    22'd3010,
      22'd3419,    22'd3896,    22'd4452,    22'd5106,    22'd5876,
      22'd6786,    22'd7866,    22'd9154,    22'd10700,   22'd12550,
      22'd14790,   22'd17520,   22'd20830,   22'd24880,   22'd29860,
      22'd36020,   22'd43680,   22'd53260,   22'd65310,   22'd80570,
      22'd100000,  22'd124920,  22'd157110,  22'd198990,  22'd253910,
      22'd326500,  22'd423260,  22'd553260,  22'd729510,  22'd970720,
      22'd1304100, 22'd1769600, 22'd2426600, 22'd3364500
   };

   function automatic logic [RES_WIDTH-1:0] point_res(input logic [IDX_WIDTH-1:0] idx);
      logic [RES_WIDTH-1:0] res;
      res = '0;
      if (int'(idx) < TABLE_STORED) begin
         res = RES_TENTHS[idx];
      end
      return res;
   endfunction

   function automatic logic signed [DEG_WIDTH-1:0] point_deg(input logic [IDX_WIDTH-1:0] idx);
      return DEG_WIDTH'(HOT_DEGREES - STEP_DEGREES * int'(idx));
   endfunction

endpackage

// ----- sv/thermistor_adc_to_temperature.sv -----
`timescale 1ns / 1ps
// From an accepted reading to rsp_valid: at or above full scale, only the load; else a
// 16-step serial multiply, a 40-step restoring divide, a scan of one table point per cycle
// and a load; readings hotter than the table or past its end load after the scan, while
// interpolating at point k adds prep, load, (FRACTION_BITS+3)-step divide and subtract.
// Throughput: one reading at a time; the next is taken the cycle after the result loads.
// Reset: synchronous, active high; control clears, the CSRs return to 1023 and 10000.

`include "assert_macros.svh"

module thermistor_adc_to_temperature #(
   parameter int TABLE_POINTS  = thadc_pkg::TABLE_POINTS_DEFAULT,
   parameter int FRACTION_BITS = thadc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [thadc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [thadc_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [thadc_pkg::READING_WIDTH-1:0]    req_reading,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [thadc_pkg::TEMP_WIDTH-1:0] rsp_temperature_q8,
   output logic [thadc_pkg::STATUS_WIDTH-1:0]     rsp_range_status
);

   localparam int TW = thadc_pkg::TEMP_WIDTH;
   localparam int TABLE_USED = (TABLE_POINTS < thadc_pkg::TABLE_STORED) ?
                               TABLE_POINTS : thadc_pkg::TABLE_STORED;
   localparam int COLD_DEGREES = thadc_pkg::HOT_DEGREES -
                                 thadc_pkg::STEP_DEGREES * (TABLE_USED - 1);
   localparam logic [TW-1:0] HOT_SCALED  = TW'(thadc_pkg::HOT_DEGREES * (1 << FRACTION_BITS));
   localparam logic [TW-1:0] COLD_SCALED = TW'(COLD_DEGREES * (1 << FRACTION_BITS));
   localparam int QW = FRACTION_BITS + thadc_pkg::STEP_BITS;
   localparam int XW = thadc_pkg::SCALED_WIDTH + FRACTION_BITS;
   localparam int WW = thadc_pkg::WORK_WIDTH;
   localparam int RW = thadc_pkg::REM_WIDTH;
   localparam int CW = thadc_pkg::CNT_WIDTH;
   localparam int IW = thadc_pkg::IDX_WIDTH;
   localparam int SW = thadc_pkg::SCALED_WIDTH;
   localparam int PW = thadc_pkg::SPAN_WIDTH;
   localparam int LW = thadc_pkg::RES_WIDTH;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_USED - 1);

   thadc_pkg::state_type state_ff, state_in;

   logic [thadc_pkg::READING_WIDTH-1:0] full_scale_ff;
   logic [thadc_pkg::SERIES_WIDTH-1:0]  series_ff;

   logic [thadc_pkg::READING_WIDTH-1:0] code_ff, code_in;
   logic [SW-1:0]  s10_ff, s10_in;
   logic [PW-1:0]  dvs_ff, dvs_in;
   logic [WW-1:0]  work_ff, work_in;
   logic [RW-1:0]  rem_ff, rem_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [TW-1:0]  temp_res_ff, temp_res_in;
   logic [thadc_pkg::STATUS_WIDTH-1:0] status_res_ff, status_res_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [TW-1:0]               rsp_temp_ff, rsp_temp_in;
   logic [thadc_pkg::STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   logic          accept;
   logic          load_rsp;
   logic          at_full_scale;
   logic [RW-1:0] shifted;
   logic [RW:0]   trial;
   logic          trial_ok;
   logic [LW-1:0] point_hi;
   logic [LW-1:0] point_lo;
   logic          point_hit;
   logic [LW-1:0] span;
   logic [LW-1:0] offset;
   logic [XW-1:0] dividend;
   logic [TW-1:0] base_scaled;

   assign accept        = req_valid && !req_stall;
   assign load_rsp      = (state_ff == thadc_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign at_full_scale = (req_reading >= full_scale_ff);

   assign shifted  = {rem_ff[RW-2:0], work_ff[WW-1]};
   assign trial    = {1'b0, shifted} - (RW+1)'(dvs_ff);
   assign trial_ok = !trial[RW];

   assign point_hi  = thadc_pkg::point_res(idx_ff);
   assign point_lo  = thadc_pkg::point_res(idx_ff - IW'(1));
   assign point_hit = (WW'(point_hi) >= work_ff);
   assign span      = point_hi - point_lo;
   assign offset    = work_ff[LW-1:0] - point_lo;
   assign dividend  = (XW'(s10_ff[SW-2:0]) << FRACTION_BITS) + XW'(dvs_ff[PW-1:1]);
   assign base_scaled = TW'(thadc_pkg::point_deg(idx_ff - IW'(1))) << FRACTION_BITS;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         thadc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = at_full_scale ? thadc_pkg::ST_DONE : thadc_pkg::ST_MUL;
            end
         end
         thadc_pkg::ST_MUL: begin
            if (cnt_ff == '0) begin
               state_in = thadc_pkg::ST_DIV;
            end
         end
         thadc_pkg::ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = thadc_pkg::ST_SCAN;
            end
         end
         thadc_pkg::ST_SCAN: begin
            if (point_hit) begin
               state_in = (idx_ff == '0) ? thadc_pkg::ST_DONE : thadc_pkg::ST_PREP;
            end else if (idx_ff == LAST_IDX) begin
               state_in = thadc_pkg::ST_DONE;
            end
         end
         thadc_pkg::ST_PREP:  state_in = thadc_pkg::ST_LOAD2;
         thadc_pkg::ST_LOAD2: state_in = thadc_pkg::ST_DIV2;
         thadc_pkg::ST_DIV2: begin
            if (cnt_ff == '0) begin
               state_in = thadc_pkg::ST_SUB;
            end
         end
         thadc_pkg::ST_SUB: state_in = thadc_pkg::ST_DONE;
         thadc_pkg::ST_DONE: begin
            if (load_rsp) begin
               state_in = thadc_pkg::ST_IDLE;
            end
         end
         default: state_in = thadc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall     = (state_ff != thadc_pkg::ST_IDLE);
      code_in       = code_ff;
      s10_in        = s10_ff;
      dvs_in        = dvs_ff;
      work_in       = work_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      temp_res_in   = temp_res_ff;
      status_res_in = status_res_ff;
      unique case (state_ff)
         thadc_pkg::ST_IDLE: begin
            code_in = req_reading;
            s10_in  = SW'(series_ff) * SW'(thadc_pkg::TENTHS_PER_OHM);
            dvs_in  = PW'(full_scale_ff - req_reading);
            work_in = '0;
            rem_in  = '0;
            cnt_in  = CW'(thadc_pkg::READING_WIDTH - 1);
            idx_in  = '0;
            temp_res_in   = COLD_SCALED;
            status_res_in = thadc_pkg::STATUS_COLD;
         end
         thadc_pkg::ST_MUL: begin
            // shift-add, one code bit per cycle, MSB first
            work_in = {work_ff[WW-2:0], 1'b0} + (code_ff[thadc_pkg::READING_WIDTH-1] ?
                      WW'(s10_ff) : WW'(0));
            code_in = {code_ff[thadc_pkg::READING_WIDTH-2:0], 1'b0};
            cnt_in  = (cnt_ff == '0) ? CW'(WW - 1) : cnt_ff - CW'(1);
         end
         thadc_pkg::ST_DIV, thadc_pkg::ST_DIV2: begin
            rem_in  = trial_ok ? trial[RW-1:0] : shifted;
            work_in = {work_ff[WW-2:0], trial_ok};
            cnt_in  = cnt_ff - CW'(1);
         end
         thadc_pkg::ST_SCAN: begin
            if (point_hit) begin
               if (idx_ff == '0) begin
                  temp_res_in   = HOT_SCALED;
                  status_res_in = (WW'(point_hi) != work_ff) ? thadc_pkg::STATUS_HOT :
                                  thadc_pkg::STATUS_IN_RANGE;
               end
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         thadc_pkg::ST_PREP: begin
            dvs_in = PW'(span);
            s10_in = SW'(offset) * SW'(thadc_pkg::STEP_DEGREES);
         end
         thadc_pkg::ST_LOAD2: begin
            // top part is below the span, so only QW quotient bits remain
            rem_in  = RW'(dividend >> QW);
            work_in = WW'(dividend[QW-1:0]) << (WW - QW);
            cnt_in  = CW'(QW - 1);
         end
         thadc_pkg::ST_SUB: begin
            temp_res_in   = base_scaled - TW'(work_ff[QW-1:0]);
            status_res_in = thadc_pkg::STATUS_IN_RANGE;
         end
         thadc_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_temp_in   = rsp_temp_ff;
      rsp_status_in = rsp_status_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_temp_in   = signed'(temp_res_ff);
         rsp_status_in = status_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= thadc_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         full_scale_ff <= thadc_pkg::FULL_SCALE_RESET;
         series_ff     <= thadc_pkg::SERIES_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               thadc_pkg::CSR_FULL_SCALE:
                  full_scale_ff <= csr_write_data[thadc_pkg::READING_WIDTH-1:0];
               thadc_pkg::CSR_SERIES:
                  series_ff <= csr_write_data[thadc_pkg::SERIES_WIDTH-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      s10_ff        <= s10_in;
      dvs_ff        <= dvs_in;
      work_ff       <= work_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      temp_res_ff   <= temp_res_in;
      status_res_ff <= status_res_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_temperature_q8 = rsp_temp_ff;
   assign rsp_range_status   = rsp_status_ff;

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, req_stall)
   `ASSERT_IMPLIES(a_load_from_done, clock, reset, $rose(rsp_valid_ff),
                   $past(state_ff) == thadc_pkg::ST_DONE)
   `ASSERT_IMPLIES(a_status_code, clock, reset, rsp_valid_ff,
                   rsp_status_ff == thadc_pkg::STATUS_IN_RANGE ||
                   rsp_status_ff == thadc_pkg::STATUS_HOT ||
                   rsp_status_ff == thadc_pkg::STATUS_COLD)
   `ASSERT_IMPLIES(a_hot_clamp, clock, reset,
                   rsp_valid_ff && rsp_status_ff == thadc_pkg::STATUS_HOT,
                   rsp_temp_ff == signed'(HOT_SCALED))
   `ASSERT_IMPLIES(a_cold_clamp, clock, reset,
                   rsp_valid_ff && rsp_status_ff == thadc_pkg::STATUS_COLD,
                   rsp_temp_ff == signed'(COLD_SCALED))

endmodule
